// File: rtl/core/srfp_pkg.sv
// Shared types and constants of the sensor reply frame parser.
package srfp_pkg;

    typedef logic [3:0] t_pos;
    typedef logic [7:0] t_byte;
    typedef logic [15:0] t_reading;

    localparam t_pos FRAME_LENGTH  = 4'd11;
    localparam t_pos POS_CHECKSUM  = 4'd10;
    localparam t_pos LAST_SUMMED   = 4'd9;
    localparam t_pos FIRST_READING = 4'd4;
    localparam t_pos POS_HDR1      = 4'd1;
    localparam t_pos POS_HDR0      = 4'd0;
    localparam t_byte HDR0         = 8'hFE;
    localparam t_byte HDR1         = 8'hA5;
    localparam int NUM_READINGS    = 3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CSUM_BAD  = 2'd1,
        ST_BAD_FRAME = 2'd2
    } t_status;

    typedef struct packed {
        t_status  status;
        t_reading pm1;
        t_reading pm25;
        t_reading pm10;
        t_byte    computed_sum;
        t_byte    received_sum;
    } t_result;

endpackage

// File: rtl/core/srfp_frame_track.sv
// Frame position, running sum, header check and reading capture for one reply.
module srfp_frame_track
    import srfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_byte   i_byte,
    input  logic    i_first,
    output logic    o_res_valid,
    output t_result o_res
);

    t_pos     r_pos, n_pos;
    logic     r_coll, n_coll;
    t_byte    r_sum, n_sum;
    logic     r_hg, n_hg;
    t_reading r_rd [NUM_READINGS];
    t_reading n_rd [NUM_READINGS];

    always_comb begin
        t_pos       off;
        logic [1:0] k;
        n_pos  = r_pos;
        n_coll = r_coll;
        n_sum  = r_sum;
        n_hg   = r_hg;
        n_rd   = r_rd;
        off    = '0;
        k      = '0;
        o_res_valid        = 1'b0;
        o_res.status       = ST_BAD_FRAME;
        o_res.pm1          = '0;
        o_res.pm25         = '0;
        o_res.pm10         = '0;
        o_res.computed_sum = r_sum;
        o_res.received_sum = '0;

        if (i_first) begin
            // A new request cuts short any reply that is only partly in.
            if (r_coll && r_pos != POS_HDR0 && r_pos < FRAME_LENGTH) begin
                o_res_valid = 1'b1;
            end
            n_coll = 1'b1;
            n_pos  = '0;
            n_sum  = '0;
            n_hg   = 1'b0;
            n_rd   = '{default: '0};
        end

        if (n_coll && n_pos < FRAME_LENGTH) begin
            if (n_pos == POS_HDR0) begin
                n_hg = (i_byte == HDR0);
            end else if (n_pos <= LAST_SUMMED) begin
                if (n_pos == POS_HDR1) begin
                    n_hg = n_hg && (i_byte == HDR1);
                end
                n_sum = n_sum + i_byte;
                if (n_pos >= FIRST_READING) begin
                    off = n_pos - FIRST_READING;
                    k   = off[2:1];
                    if (!off[0]) begin
                        n_rd[k] = {i_byte, 8'h00};
                    end else begin
                        n_rd[k] = n_rd[k] | {8'h00, i_byte};
                    end
                end
            end else if (n_pos == POS_CHECKSUM) begin
                o_res_valid        = 1'b1;
                o_res.computed_sum = n_sum;
                o_res.received_sum = i_byte;
                if (!n_hg) begin
                    o_res.status = ST_BAD_FRAME;
                end else if (n_sum == i_byte) begin
                    o_res.status = ST_OK;
                    o_res.pm1    = n_rd[0];
                    o_res.pm25   = n_rd[1];
                    o_res.pm10   = n_rd[2];
                end else begin
                    o_res.status = ST_CSUM_BAD;
                end
                n_coll = 1'b0;
            end
            n_pos = n_pos + 4'd1;
        end

        if (!i_step) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_coll <= 1'b0;
            r_sum  <= '0;
            r_hg   <= 1'b0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_coll <= n_coll;
            r_sum  <= n_sum;
            r_hg   <= n_hg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_rd <= n_rd;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= FRAME_LENGTH)
        else $error("byte position ran past the frame length");

    a_done_not_collecting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == FRAME_LENGTH) |-> !r_coll)
        else $error("still collecting after the checksum byte");

endmodule

// File: rtl/core/srfp_out_reg.sv
// Result register that holds one result item until the receiver takes it.
module srfp_out_reg
    import srfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_take,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!r_valid || i_take))
        else $error("result pushed over one not yet taken");

    a_ok_sums_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status == ST_OK) |-> (r_res.computed_sum == r_res.received_sum))
        else $error("ok result with mismatching sums");

endmodule

// File: rtl/core/sensor_reply_frame_parser_unit.sv
// Top level of the sensor reply frame parser: input register, frame tracker, result register.
//
// The input channel (i_in_valid / o_in_ready) carries one received reply byte per item,
// with i_first_of_reply set on the first byte after a new request. A reply is eleven
// bytes: header bytes FE and A5, readings in bytes 4 to 9, and a modulo-256 checksum of
// bytes 1 to 9 in byte 10.
// The output channel (o_out_valid / i_out_ready) carries one result item when the
// checksum byte arrives (status ok, checksum mismatch or bad header) or when a flagged
// byte cuts a partly received reply short (status bad frame). Readings are zero unless
// the status is ok. Bytes after the eleventh, and bytes before any flagged byte, give no
// result.
// An item accepted at a clock edge is held in the input register and processed by the
// frame tracker at a later edge at which the result register is free or being emptied;
// its result, if any, is shown on the output ports right after that edge. One
// item is accepted every cycle as long as the result register is free or being emptied.
// When the receiver stalls, the pending result holds; the input register still takes
// one more item, and then o_in_ready falls until the result is taken.
// Reset clears the position, collecting flag, sum, header flag and both valid flags,
// so the block starts idle and ignores bytes until a flagged first byte.
module sensor_reply_frame_parser_unit
    import srfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_first_of_reply,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_reading_pm1,
    output logic [15:0] o_reading_pm25,
    output logic [15:0] o_reading_pm10,
    output logic [7:0]  o_computed_sum,
    output logic [7:0]  o_received_sum
);

    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_in_first;
    logic    w_out_free;
    logic    w_step;
    logic    w_res_valid;
    logic    w_accept;
    t_result w_res;
    t_result w_out_res;

    // The held byte moves on whenever the result register can take what it produces.
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte  <= i_rx_byte;
            r_in_first <= i_first_of_reply;
        end
    end

    srfp_frame_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_first     (r_in_first),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    srfp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .i_take  (i_out_ready),
        .o_valid (o_out_valid),
        .o_free  (w_out_free),
        .o_res   (w_out_res)
    );

    assign o_status       = w_out_res.status;
    assign o_reading_pm1  = w_out_res.pm1;
    assign o_reading_pm25 = w_out_res.pm25;
    assign o_reading_pm10 = w_out_res.pm10;
    assign o_computed_sum = w_out_res.computed_sum;
    assign o_received_sum = w_out_res.received_sum;

    // A held byte is never lost: it either steps or stays in place.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte was dropped or changed");

endmodule

// File: bench/srfp_reply_checker.sv
// Checker for the sensor reply frame parser: predicts every reply result and compares it.
module srfp_reply_checker
    import srfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_first_of_reply,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_reading_pm1,
    input  logic [15:0] i_reading_pm25,
    input  logic [15:0] i_reading_pm10,
    input  logic [7:0]  i_computed_sum,
    input  logic [7:0]  i_received_sum,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Our own copy of the frame tracker.
    t_pos     frame_pos;
    logic     frame_open;
    t_byte    frame_sum;
    logic     header_seen_ok;
    t_reading frame_readings [NUM_READINGS];

    t_result  awaited_replies [$];
    int       failures = 0;

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
        end
    endtask

    // Advances the tracker by one accepted byte and queues the result it causes, if any.
    task automatic track_reply_byte(input t_byte rx, input logic first);
        t_result r;
        int offset;
        if (first) begin
            // A flag in the middle of a reply cuts it short.
            if (frame_open && frame_pos > POS_HDR0 && frame_pos < FRAME_LENGTH) begin
                r = '0;
                r.status = ST_BAD_FRAME;
                r.computed_sum = frame_sum;
                awaited_replies.push_back(r);
            end
            frame_open = 1'b1;
            frame_pos = POS_HDR0;
            frame_sum = '0;
            header_seen_ok = 1'b0;
            frame_readings = '{default: '0};
        end
        if (frame_open && frame_pos < FRAME_LENGTH) begin
            if (frame_pos == POS_HDR0) begin
                header_seen_ok = (rx == HDR0);
            end else if (frame_pos <= LAST_SUMMED) begin
                if (frame_pos == POS_HDR1) begin
                    header_seen_ok = header_seen_ok && (rx == HDR1);
                end
                frame_sum = frame_sum + rx;
                if (frame_pos >= FIRST_READING) begin
                    offset = int'(frame_pos) - int'(FIRST_READING);
                    if (offset % 2 == 0) begin
                        frame_readings[offset / 2] = {rx, 8'h00};
                    end else begin
                        frame_readings[offset / 2] = frame_readings[offset / 2] | t_reading'(rx);
                    end
                end
            end else begin
                // Checksum byte: the reply is complete.
                r = '0;
                if (!header_seen_ok) begin
                    r.status = ST_BAD_FRAME;
                end else if (frame_sum == rx) begin
                    r.status = ST_OK;
                end else begin
                    r.status = ST_CSUM_BAD;
                end
                if (r.status == ST_OK) begin
                    r.pm1 = frame_readings[0];
                    r.pm25 = frame_readings[1];
                    r.pm10 = frame_readings[2];
                end
                r.computed_sum = frame_sum;
                r.received_sum = rx;
                awaited_replies.push_back(r);
                frame_open = 1'b0;
            end
            frame_pos = frame_pos + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            frame_pos = POS_HDR0;
            frame_open = 1'b0;
            frame_sum = '0;
            header_seen_ok = 1'b0;
            frame_readings = '{default: '0};
            awaited_replies.delete();
        end else begin
            // Results are checked before the new byte is tracked; a byte's result shows up
            // only after the byte has left the input register, so they never share an edge.
            if (i_out_valid && i_out_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("result with status %0d arrived while none was expected", i_status);
                    failures++;
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("status", want.status, i_status);
                    compare_field("reading_pm1", want.pm1, i_reading_pm1);
                    compare_field("reading_pm25", want.pm25, i_reading_pm25);
                    compare_field("reading_pm10", want.pm10, i_reading_pm10);
                    compare_field("computed_sum", want.computed_sum, i_computed_sum);
                    compare_field("received_sum", want.received_sum, i_received_sum);
                end
            end
            if (i_in_valid && i_in_ready) begin
                track_reply_byte(i_rx_byte, i_first_of_reply);
            end
        end
        o_pending <= awaited_replies.size();
        o_fail_count <= failures;
    end

endmodule

// File: bench/sensor_reply_frame_parser_unit_test.sv
// Testbench top of the sensor reply frame parser: clock, reset, stimulus, watchdog and verdict.
module sensor_reply_frame_parser_unit_test;
    import srfp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted item before the run is declared hung. The longest
    // quiet stretch is the receiver's deliberate hold, far below this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the receiver's long hold, long enough for the block to fill up.
    localparam int RX_HOLD_CYCLES = 160;
    // Cycles allowed after the last expected result so that a stray one is caught.
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_TARGET = 700;

    typedef logic [FRAME_LENGTH-1:0][7:0] t_frame_bytes;
    typedef enum int {RK_GOOD, RK_CSUM_BAD, RK_BAD_HDR} t_reply_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_first_of_reply = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_reading_pm1;
    logic [15:0] o_reading_pm25;
    logic [15:0] o_reading_pm10;
    logic [7:0]  o_computed_sum;
    logic [7:0]  o_received_sum;

    int check_failures;
    int results_awaited;

    // Pacing controls shared between the stimulus and the receiver. When a side is
    // calm it never idles; the receiver hold request asks for one long stall.
    bit sender_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit rx_hold_req = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    sensor_reply_frame_parser_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_first_of_reply (i_first_of_reply),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_reading_pm1    (o_reading_pm1),
        .o_reading_pm25   (o_reading_pm25),
        .o_reading_pm10   (o_reading_pm10),
        .o_computed_sum   (o_computed_sum),
        .o_received_sum   (o_received_sum)
    );

    srfp_reply_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_first_of_reply (i_first_of_reply),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_status         (o_status),
        .i_reading_pm1    (o_reading_pm1),
        .i_reading_pm25   (o_reading_pm25),
        .i_reading_pm10   (o_reading_pm10),
        .i_computed_sum   (o_computed_sum),
        .i_received_sum   (o_received_sum),
        .o_fail_count     (check_failures),
        .o_pending        (results_awaited)
    );

    // Byte values lean toward the extremes so that readings and sums hit their edges.
    function automatic t_byte pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return t_byte'($urandom());
        endcase
    endfunction

    // Fills in the checksum byte as the modulo-256 sum of bytes 1 to 9.
    function automatic t_frame_bytes with_checksum(input t_frame_bytes f);
        t_byte acc;
        acc = '0;
        for (int i = POS_HDR1; i <= LAST_SUMMED; i++) begin
            acc = acc + f[i];
        end
        f[POS_CHECKSUM] = acc;
        return f;
    endfunction

    // Offers one item and returns right after the edge at which it was accepted. It
    // is always called just after a rising edge. Valid is only lowered when a gap is
    // drawn, so back-to-back items keep it high without a glitch.
    task automatic offer_byte(input t_byte b, input logic first);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        i_first_of_reply <= first;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Sends the first len bytes of a reply; only its first byte carries the flag.
    task automatic send_frame(input t_frame_bytes f, input int len);
        for (int i = 0; i < len; i++) begin
            offer_byte(f[i], i == 0);
            items_sent++;
        end
    endtask

    // Builds a reply with random content. Bad-header replies break one of the two
    // header bytes and sometimes the checksum as well.
    task automatic send_random_reply(input t_reply_kind kind, input int len);
        t_frame_bytes f;
        f[POS_HDR0] = HDR0;
        f[POS_HDR1] = HDR1;
        for (int i = 2; i < FRAME_LENGTH; i++) begin
            f[i] = pick_byte();
        end
        if (kind == RK_BAD_HDR) begin
            if ($urandom_range(0, 1) == 1) begin
                f[POS_HDR0] = HDR0 ^ t_byte'($urandom_range(1, 255));
            end else begin
                f[POS_HDR1] = HDR1 ^ t_byte'($urandom_range(1, 255));
            end
        end
        f = with_checksum(f);
        if (kind == RK_CSUM_BAD || (kind == RK_BAD_HDR && $urandom_range(0, 1) == 1)) begin
            f[POS_CHECKSUM] = f[POS_CHECKSUM] + t_byte'($urandom_range(1, 255));
        end
        send_frame(f, len);
    endtask

    // Receiver: for every result it draws a wait with ready low, then holds ready
    // high until a result is taken. On request it instead stalls for a long stretch.
    initial begin : result_taker
        int wait_cycles;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                wait_cycles = rx_calm ? 0 : $urandom_range(0, 13);
                if (wait_cycles > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_frame_bytes f;
        int roll;
        int reply_no;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A byte before any flag must be ignored.
        offer_byte(8'h5A, 1'b0);
        // A good reply with readings FFFF, 0000 and 8001; the sum wraps.
        f = with_checksum({8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                           HDR1, HDR0});
        send_frame(f, FRAME_LENGTH);
        // A trailing byte after a complete reply is ignored.
        offer_byte(8'hFF, 1'b0);
        // The flag after a complete reply starts a new one without a result. This
        // one has a bad first header byte but a correct checksum, so the readings
        // must come out as zero.
        f = with_checksum({8'h00, 8'h9A, 8'h78, 8'h56, 8'h34, 8'h12, 8'hEF, 8'hCD, 8'hAB,
                           HDR1, 8'h00});
        send_frame(f, FRAME_LENGTH);
        // A reply cut short after its header; the next flagged byte ends it.
        f[POS_HDR0] = HDR0;
        send_frame(f, 2);

        // Random part. Most traffic is well-formed replies with random content; the
        // rest are checksum errors, broken headers, short replies and loose bytes.
        reply_no = 0;
        while (items_sent < ITEM_TARGET) begin
            if (reply_no % 8 == 0) begin
                sender_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (reply_no == 20) begin
                // The receiver stalls while the sender keeps offering full replies at
                // full rate: the result register fills and the input must back off.
                rx_hold_req = 1'b1;
                sender_calm = 1'b1;
                repeat (4) send_random_reply(RK_GOOD, FRAME_LENGTH);
            end
            if (reply_no == 40) begin
                // The sender goes quiet until every expected result has come back.
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (results_awaited != 0) @(posedge i_clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                send_random_reply(RK_GOOD, FRAME_LENGTH);
            end else if (roll < 65) begin
                send_random_reply(RK_CSUM_BAD, FRAME_LENGTH);
            end else if (roll < 75) begin
                send_random_reply(RK_BAD_HDR, FRAME_LENGTH);
            end else if (roll < 90) begin
                send_random_reply(t_reply_kind'($urandom_range(0, 2)), $urandom_range(1, 10));
            end else begin
                // Loose bytes: trailing junk, with an occasional stray flag.
                repeat ($urandom_range(1, 4)) offer_byte(pick_byte(), $urandom_range(0, 7) == 0);
            end
            reply_no++;
        end

        // Wind down: the pending count is registered, so step past an edge before looking.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_awaited != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (check_failures == 0 && results_awaited == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
